// ----- rtl/bfi_pkg.sv -----
// Shared constants, command codes and result type of the tape-language interpreter core.
package bfi_pkg;

  // Storage sizes
  localparam int unsigned TapeCells  = 32768;
  localparam int unsigned TapeAw     = $clog2(TapeCells);
  localparam int unsigned ProgDepth  = 4096;
  localparam int unsigned ProgAw     = $clog2(ProgDepth);
  localparam int unsigned ProgLenW   = $clog2(ProgDepth + 1);
  localparam int unsigned StackDepth = 64;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned StackCntW  = $clog2(StackDepth + 1);
  localparam int unsigned InDepth    = 1024;
  localparam int unsigned InAw       = $clog2(InDepth);
  localparam int unsigned InCntW     = $clog2(InDepth + 1);

  // Stream widths
  localparam int unsigned InTdataW   = 8;
  localparam int unsigned InTuserW   = 2;
  localparam int unsigned OutTdataW  = 16;

  // Program commands
  localparam logic [7:0] CmdRight = 8'h3E;
  localparam logic [7:0] CmdLeft  = 8'h3C;
  localparam logic [7:0] CmdInc   = 8'h2B;
  localparam logic [7:0] CmdDec   = 8'h2D;
  localparam logic [7:0] CmdOut   = 8'h2E;
  localparam logic [7:0] CmdIn    = 8'h2C;
  localparam logic [7:0] CmdOpen  = 8'h5B;
  localparam logic [7:0] CmdClose = 8'h5D;

  // Item kinds on the input stream
  localparam logic [1:0] ActProg  = 2'd0;
  localparam logic [1:0] ActInput = 2'd1;
  localparam logic [1:0] ActStep  = 2'd2;

  // Status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StOverflow  = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic       halted;
    logic [7:0] out_byte;
    logic       out_valid;
  } result_t;

endpackage

// ----- rtl/brainfuck_interpreter_core_unit.sv -----
// Top level of the tape-language interpreter core: sequencer, memories and output stage.
//
// Input stream (s_axis): tuser selects the item kind (append program byte, append
// input byte, execute one instruction), tdata carries the byte for the append kinds.
// Output stream (m_axis): one item per execute item, none for append items;
// tuser flags an output command, tdata holds the emitted byte, halted and status.
// Append items finish as they are accepted. An execute item first reads the program,
// tape, input and bracket memories, then updates and writes back. A forward bracket
// on a zero cell adds a scan of the program bytes up to the matching bracket, which
// the program memory gives one byte a cycle.
// After reset all TapeCells (32768) cells of the tape memory are cleared one cell a
// cycle, and s_axis_tready_o stays low throughout.
// The result goes to an output register; the next item is accepted while it waits.
// If the receiver stalls and a new result is ready, the block holds the result
// and accepts nothing further until the output register frees up.
module brainfuck_interpreter_core_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: data_byte[7:0]
  input  logic [bfi_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [bfi_pkg::InTuserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: out_byte[7:0], halted[8], status[10:9], zero fill
  output logic [bfi_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // tuser: out_valid
  output logic                          m_axis_tuser_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StExec  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StResp  = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [bfi_pkg::ProgLenW-1:0]    len_q, len_d;
  logic [bfi_pkg::ProgLenW-1:0]    ip_q, ip_d;
  logic [bfi_pkg::TapeAw-1:0]      dp_q, dp_d;
  logic [bfi_pkg::StackCntW-1:0]   sc_q, sc_d;
  logic [bfi_pkg::InCntW-1:0]      wr_q, wr_d;
  logic [bfi_pkg::InCntW-1:0]      rd_q, rd_d;
  logic [1:0]                      err_q, err_d;
  logic [bfi_pkg::ProgLenW-1:0]    depth_q, depth_d;
  logic [bfi_pkg::TapeAw-1:0]      clr_q, clr_d;
  bfi_pkg::result_t                res_q, res_d;

  // Memory ports
  logic                            prog_we;
  logic [7:0]                      prog_rd;
  logic                            tape_we;
  logic [bfi_pkg::TapeAw-1:0]      tape_waddr;
  logic [7:0]                      tape_wdata;
  logic [7:0]                      tape_rd;
  logic                            in_we;
  logic [7:0]                      in_rd;
  logic                            stk_we;
  logic [bfi_pkg::ProgAw-1:0]      stk_rd;
  logic [bfi_pkg::StackCntW-1:0]   sc_m1;

  // Output stage
  logic                            out_ld;
  logic                            out_free;
  bfi_pkg::result_t                out_res;

  logic                            accept;
  logic                            halted_now;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign halted_now      = (err_q != bfi_pkg::StOk) || (ip_q >= len_q);
  assign sc_m1           = sc_q - bfi_pkg::StackCntW'(1);

  // Sequencer and read-modify-write datapath
  always_comb begin
    logic                         fin;
    logic                         o_valid;
    logic [7:0]                   o_byte;
    logic [bfi_pkg::ProgLenW-1:0] ip_n;
    logic [bfi_pkg::ProgLenW-1:0] depth_n;
    bfi_pkg::result_t             r;

    state_d    = state_q;
    len_d      = len_q;
    ip_d       = ip_q;
    dp_d       = dp_q;
    sc_d       = sc_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    err_d      = err_q;
    depth_d    = depth_q;
    clr_d      = clr_q;
    res_d      = res_q;
    prog_we    = 1'b0;
    tape_we    = 1'b0;
    tape_waddr = dp_q;
    tape_wdata = tape_rd;
    in_we      = 1'b0;
    stk_we     = 1'b0;
    out_ld     = 1'b0;
    out_res    = res_q;
    fin        = 1'b0;
    o_valid    = 1'b0;
    o_byte     = 8'd0;
    ip_n       = ip_q + bfi_pkg::ProgLenW'(1);
    depth_n    = depth_q;
    r          = '0;

    case (state_q)
      // Zero the tape one cell a cycle
      StClear: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = 8'd0;
        if (clr_q == bfi_pkg::TapeAw'(bfi_pkg::TapeCells - 1)) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + bfi_pkg::TapeAw'(1);
        end
      end

      // Take items; append kinds finish here
      StIdle: begin
        if (accept) begin
          case (s_axis_tuser_i)
            bfi_pkg::ActProg: begin
              if (len_q < bfi_pkg::ProgLenW'(bfi_pkg::ProgDepth)) begin
                prog_we = 1'b1;
                len_d   = len_q + bfi_pkg::ProgLenW'(1);
              end
            end
            bfi_pkg::ActInput: begin
              if (wr_q < bfi_pkg::InCntW'(bfi_pkg::InDepth)) begin
                in_we = 1'b1;
                wr_d  = wr_q + bfi_pkg::InCntW'(1);
              end
            end
            bfi_pkg::ActStep: begin
              state_d = StExec;
            end
            default: begin
            end
          endcase
        end
      end

      // Memory read data valid: decode and write back
      StExec: begin
        fin = 1'b1;
        if (!halted_now) begin
          case (prog_rd)
            bfi_pkg::CmdRight: begin
              dp_d = (dp_q == bfi_pkg::TapeAw'(bfi_pkg::TapeCells - 1)) ? '0 :
                     dp_q + bfi_pkg::TapeAw'(1);
              ip_d = ip_n;
            end
            bfi_pkg::CmdLeft: begin
              dp_d = (dp_q == '0) ? bfi_pkg::TapeAw'(bfi_pkg::TapeCells - 1) :
                     dp_q - bfi_pkg::TapeAw'(1);
              ip_d = ip_n;
            end
            bfi_pkg::CmdInc: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd + 8'd1;
              ip_d       = ip_n;
            end
            bfi_pkg::CmdDec: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd - 8'd1;
              ip_d       = ip_n;
            end
            bfi_pkg::CmdOut: begin
              o_valid = 1'b1;
              o_byte  = tape_rd;
              ip_d    = ip_n;
            end
            bfi_pkg::CmdIn: begin
              if (rd_q < wr_q) begin
                tape_we    = 1'b1;
                tape_wdata = in_rd;
                rd_d       = rd_q + bfi_pkg::InCntW'(1);
              end
              ip_d = ip_n;
            end
            bfi_pkg::CmdOpen: begin
              if (tape_rd == 8'd0) begin
                // Skip forward to the matching bracket
                depth_d = bfi_pkg::ProgLenW'(1);
                if (ip_n >= len_q) begin
                  ip_d = len_q;
                end else begin
                  ip_d    = ip_n;
                  fin     = 1'b0;
                  state_d = StScan;
                end
              end else if (sc_q >= bfi_pkg::StackCntW'(bfi_pkg::StackDepth)) begin
                err_d = bfi_pkg::StOverflow;
              end else begin
                stk_we = 1'b1;
                sc_d   = sc_q + bfi_pkg::StackCntW'(1);
                ip_d   = ip_n;
              end
            end
            bfi_pkg::CmdClose: begin
              if (sc_q == '0) begin
                err_d = bfi_pkg::StUnderflow;
              end else if (tape_rd != 8'd0) begin
                ip_d = bfi_pkg::ProgLenW'(stk_rd) + bfi_pkg::ProgLenW'(1);
              end else begin
                sc_d = sc_m1;
                ip_d = ip_n;
              end
            end
            default: begin
              ip_d = ip_n;
            end
          endcase
        end
      end

      // One program byte a cycle while tracking bracket depth
      StScan: begin
        case (prog_rd)
          bfi_pkg::CmdOpen:  depth_n = depth_q + bfi_pkg::ProgLenW'(1);
          bfi_pkg::CmdClose: depth_n = depth_q - bfi_pkg::ProgLenW'(1);
          default:           depth_n = depth_q;
        endcase
        depth_d = depth_n;
        if (depth_n == '0) begin
          ip_d = ip_n;
          fin  = 1'b1;
        end else if (ip_n >= len_q) begin
          ip_d = len_q;
          fin  = 1'b1;
        end else begin
          ip_d = ip_n;
        end
      end

      // Result waits for the output register
      StResp: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_res = res_q;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Build the result item of a finished step
    if (fin) begin
      r.out_valid = o_valid;
      r.out_byte  = o_byte;
      r.halted    = (err_d != bfi_pkg::StOk) || (ip_d >= len_q);
      r.status    = err_d;
      if (out_free) begin
        out_ld  = 1'b1;
        out_res = r;
        state_d = StIdle;
      end else begin
        res_d   = r;
        state_d = StResp;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      len_q   <= '0;
      ip_q    <= '0;
      dp_q    <= '0;
      sc_q    <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      err_q   <= bfi_pkg::StOk;
      depth_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ip_q    <= ip_d;
      dp_q    <= dp_d;
      sc_q    <= sc_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      err_q   <= err_d;
      depth_q <= depth_d;
      clr_q   <= clr_d;
    end
  end

  // Held result, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Program store
  bfi_ram #(
    .Width (8),
    .Depth (bfi_pkg::ProgDepth)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (len_q[bfi_pkg::ProgAw-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (ip_d[bfi_pkg::ProgAw-1:0]),
    .rdata_o (prog_rd)
  );

  // Tape
  bfi_ram #(
    .Width (8),
    .Depth (bfi_pkg::TapeCells)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (dp_q),
    .rdata_o (tape_rd)
  );

  // Input byte buffer
  bfi_ram #(
    .Width (8),
    .Depth (bfi_pkg::InDepth)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (wr_q[bfi_pkg::InAw-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (rd_q[bfi_pkg::InAw-1:0]),
    .rdata_o (in_rd)
  );

  // Open-bracket stack, top entry read ahead
  bfi_ram #(
    .Width (bfi_pkg::ProgAw),
    .Depth (bfi_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sc_q[bfi_pkg::StackAw-1:0]),
    .wdata_i (ip_q[bfi_pkg::ProgAw-1:0]),
    .raddr_i (sc_m1[bfi_pkg::StackAw-1:0]),
    .rdata_o (stk_rd)
  );

  // Output register
  bfi_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_ld),
    .result_i        (out_res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

`ifndef SYNTHESIS
  // No item is taken while the tape is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !s_axis_tready_o)
    else $error("item accepted during tape clear");

  // Bracket stack never holds more than its depth
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= bfi_pkg::StackCntW'(bfi_pkg::StackDepth))
    else $error("bracket stack count out of range");

  // An error halts the block for good
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != bfi_pkg::StOk) |=> (err_q == $past(err_q)))
    else $error("error status changed after being set");

  // Instruction pointer never runs past the program end
  a_ip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ip_q <= len_q)
    else $error("instruction pointer beyond program length");

  // A result is only written into a free output register
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten");
`endif

endmodule

// ----- rtl/bfi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bfi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bfi_outbuf.sv -----
// Output register that holds one result item until the downstream side takes it.
module bfi_outbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  bfi_pkg::result_t              result_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: out_byte[7:0], halted[8], status[10:9], zero fill
  output logic [bfi_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // tuser: out_valid
  output logic                          m_axis_tuser_o
);

  logic             valid_q, valid_d;
  bfi_pkg::result_t data_q;

  // Slot is free when empty or emptying this cycle
  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = data_q.out_valid;
  assign m_axis_tdata_o  = {(bfi_pkg::OutTdataW - 11)'(0), data_q.status, data_q.halted,
                            data_q.out_byte};

endmodule
